### rtl/core/sporadic_server_budget_top_defines.svh
// assertion helpers for the sporadic server budget engine
// each macro expects clk and rst_n in the scope where it is used
`ifndef SPORADIC_SERVER_BUDGET_TOP_DEFINES_SVH
`define SPORADIC_SERVER_BUDGET_TOP_DEFINES_SVH

// same-cycle implication
`define SSB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssb same-cycle check failed");

// next-cycle implication
`define SSB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssb next-cycle check failed");

`endif

### rtl/core/ssb_pkg.sv
package ssb_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int TIME_W    = 64;
    localparam int BUDGET_W  = 32;
    localparam int PENDING_W = 5;
    localparam int OUT_W     = 48;   // 41 payload bits padded to whole bytes
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // register index, taken from paddr bit 2
    localparam logic REG_BUDGET_LIMIT = 1'b0;
    localparam logic REG_PERIOD       = 1'b1;

    typedef enum logic [1:0] {
        CMD_ACTIVATE = 2'd0,
        CMD_COMPLETE = 2'd1,
        CMD_CONSUME  = 2'd2,
        CMD_DRAIN    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_ACTIVE    = 2'd1,
        MODE_EXHAUSTED = 2'd2
    } mode_t;

    typedef struct packed {
        logic [TIME_W-1:0]   due;
        logic [BUDGET_W-1:0] amount;
    } entry_t;

endpackage

### rtl/core/sporadic_server_budget_top.sv
// flow: an accepted command passes ST_EXEC and then ST_DONE, which registers its word on the output;
//   a drain on a non-empty queue also loops in ST_CHECK over the entries examined (at most QUEUE_DEPTH)
// a new command is taken only in ST_IDLE, once the previous word is in the output register;
//   ST_DONE waits while that register is full and not taken, and the drain loop reads one entry per cycle
// reset: rst_n (async, low) clears mode, budget, limit, period, pointers and fill;
//   queue memory is not cleared, the fill count guards every read
module sporadic_server_budget_top #(
    parameter int QUEUE_DEPTH = ssb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ssb_pkg::TIME_W-1:0]     s_axis_tdata,   // [63:0] now
    input  logic [1:0]                     s_axis_tuser,   // [1:0] cmd
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] consume_granted, [2:1] mode, [34:3] budget_left,
    // [39:35] pending_count, [40] push_dropped, [47:41] zero
    output logic [ssb_pkg::OUT_W-1:0]      m_axis_tdata,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ssb_pkg::APB_AW-1:0]     paddr,
    input  logic [ssb_pkg::APB_DW-1:0]     pwdata,
    output logic [ssb_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

`include "sporadic_server_budget_top_defines.svh"

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TW     = ssb_pkg::TIME_W;
    localparam int BW     = ssb_pkg::BUDGET_W;

    typedef enum logic [1:0] {
        ST_IDLE,    // waiting for a command word
        ST_EXEC,    // apply command, start drain read
        ST_CHECK,   // drain loop: head entry data is on the memory output
        ST_DONE     // hand the result to the output register
    } state_t;

    // ---------------------------------------------------------------
    // control and state registers
    // ---------------------------------------------------------------
    state_t                state_reg,    state_next;
    ssb_pkg::cmd_t         cmd_reg,      cmd_next;
    logic [TW-1:0]         now_reg,      now_next;
    ssb_pkg::mode_t        mode_reg,     mode_next;
    logic [BW-1:0]         budget_reg,   budget_next;
    logic [BW-1:0]         consumed_reg, consumed_next;
    logic [TW-1:0]         stamp_reg,    stamp_next;
    logic [BW-1:0]         limit_reg,    limit_next;
    logic [BW-1:0]         period_reg,   period_next;
    logic [PTR_W-1:0]      head_reg,     head_next;
    logic [PTR_W-1:0]      tail_reg,     tail_next;
    logic [FILL_W-1:0]     fill_reg,     fill_next;
    logic                  granted_reg,  granted_next;
    logic                  dropped_reg,  dropped_next;
    logic                  m_valid_reg,  m_valid_next;
    logic [ssb_pkg::OUT_W-1:0] m_data_reg, m_data_next;

    // ---------------------------------------------------------------
    // replenishment memory: one write port, one registered read port
    // pushes happen only in ST_EXEC and reads only in the drain loop,
    // so the FSM keeps write and read of one entry from overlapping
    // ---------------------------------------------------------------
    ssb_pkg::entry_t       mem [QUEUE_DEPTH];
    ssb_pkg::entry_t       rd_entry_reg;
    ssb_pkg::entry_t       wr_entry;
    logic                  mem_we;
    logic                  mem_re;
    logic [PTR_W-1:0]      rd_addr;

    // helpers
    logic                  s_accept;
    logic                  cfg_write;
    logic                  out_free;
    logic                  push_req;
    logic                  pop;
    logic [BW-1:0]         push_amt;
    logic [TW-1:0]         push_due;
    logic [BW:0]           drain_sum;
    logic [BW-1:0]         consumed_inc;
    logic [BW-1:0]         budget_dec;
    logic [PTR_W-1:0]      head_inc;
    logic [PTR_W-1:0]      tail_inc;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // apb: always ready, write lands on the access cycle
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == ssb_pkg::REG_PERIOD) ? period_reg : limit_reg;

    // ring pointer increments wrap at the queue depth
    assign head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    // due time wraps modulo 2^64
    assign push_due     = stamp_reg + TW'(period_reg);
    assign consumed_inc = (consumed_reg == '1) ? consumed_reg : consumed_reg + 1'b1;
    assign budget_dec   = budget_reg - 1'b1;
    assign drain_sum    = {1'b0, budget_reg} + {1'b0, rd_entry_reg.amount};

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        now_next      = now_reg;
        mode_next     = mode_reg;
        budget_next   = budget_reg;
        consumed_next = consumed_reg;
        stamp_next    = stamp_reg;
        limit_next    = limit_reg;
        period_next   = period_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        granted_next  = granted_reg;
        dropped_next  = dropped_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        rd_addr       = head_reg;
        push_req      = 1'b0;
        push_amt      = consumed_reg;
        pop           = 1'b0;
        wr_entry      = '{due: push_due, amount: push_amt};

        // output word leaves on handshake
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    cmd_next     = ssb_pkg::cmd_t'(s_axis_tuser);
                    now_next     = s_axis_tdata;
                    granted_next = 1'b0;
                    dropped_next = 1'b0;
                    state_next   = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_DONE;
                unique case (cmd_reg)
                    ssb_pkg::CMD_ACTIVATE:
                    begin
                        if (mode_reg == ssb_pkg::MODE_IDLE)
                        begin
                            mode_next     = ssb_pkg::MODE_ACTIVE;
                            stamp_next    = now_reg;
                            consumed_next = '0;
                        end
                    end

                    ssb_pkg::CMD_COMPLETE:
                    begin
                        if (mode_reg == ssb_pkg::MODE_ACTIVE)
                        begin
                            push_req      = (consumed_reg != '0);
                            push_amt      = consumed_reg;
                            mode_next     = ssb_pkg::MODE_IDLE;
                            consumed_next = '0;
                        end
                    end

                    ssb_pkg::CMD_CONSUME:
                    begin
                        if (mode_reg != ssb_pkg::MODE_IDLE)
                        begin
                            if (budget_reg == '0)
                            begin
                                mode_next = ssb_pkg::MODE_EXHAUSTED;
                            end
                            else
                            begin
                                budget_next   = budget_dec;
                                consumed_next = consumed_inc;
                                if (budget_dec == '0)
                                begin
                                    // last tick: book its replenishment, go exhausted
                                    push_req  = 1'b1;
                                    push_amt  = consumed_inc;
                                    mode_next = ssb_pkg::MODE_EXHAUSTED;
                                end
                                else
                                begin
                                    granted_next = 1'b1;
                                end
                            end
                        end
                    end

                    ssb_pkg::CMD_DRAIN:
                    begin
                        if (fill_reg != '0)
                        begin
                            mem_re     = 1'b1;
                            rd_addr    = head_reg;
                            state_next = ST_CHECK;
                        end
                    end
                endcase
            end

            ST_CHECK:
            begin
                if (rd_entry_reg.due > now_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // pop one due entry, add its amount capped at the limit
                    pop       = 1'b1;
                    head_next = head_inc;
                    fill_next = fill_reg - 1'b1;
                    if (drain_sum > {1'b0, limit_reg})
                    begin
                        budget_next = limit_reg;
                    end
                    else
                    begin
                        budget_next = drain_sum[BW-1:0];
                    end
                    if ((budget_next != '0) && (mode_reg == ssb_pkg::MODE_EXHAUSTED))
                    begin
                        mode_next = ssb_pkg::MODE_ACTIVE;
                    end
                    if (fill_reg == FILL_W'(1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // fetch the next head entry while this one retires
                        mem_re  = 1'b1;
                        rd_addr = head_inc;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, dropped_reg, ssb_pkg::PENDING_W'(fill_reg),
                                    budget_reg, mode_reg, granted_reg};
                    state_next   = ST_IDLE;
                end
            end
        endcase

        // ring push, dropped when full
        wr_entry = '{due: push_due, amount: push_amt};
        if (push_req)
        begin
            if (fill_reg == FILL_W'(QUEUE_DEPTH))
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                mem_we    = 1'b1;
                tail_next = tail_inc;
                fill_next = fill_reg + 1'b1;
            end
        end

        // register write acts as init; the user must write only while the engine is idle, the block does not enforce it
        if (cfg_write)
        begin
            if (paddr[2] == ssb_pkg::REG_BUDGET_LIMIT)
            begin
                limit_next = pwdata;
            end
            else
            begin
                period_next = pwdata;
            end
            budget_next   = (paddr[2] == ssb_pkg::REG_BUDGET_LIMIT) ? pwdata : limit_reg;
            consumed_next = '0;
            stamp_next    = '0;
            mode_next     = ssb_pkg::MODE_IDLE;
            head_next     = '0;
            tail_next     = '0;
            fill_next     = '0;
        end
    end

    // state, control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= ssb_pkg::MODE_IDLE;
            budget_reg   <= '0;
            consumed_reg <= '0;
            stamp_reg    <= '0;
            limit_reg    <= '0;
            period_reg   <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            budget_reg   <= budget_next;
            consumed_reg <= consumed_next;
            stamp_reg    <= stamp_next;
            limit_reg    <= limit_next;
            period_reg   <= period_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        now_reg     <= now_next;
        granted_reg <= granted_next;
        dropped_reg <= dropped_next;
        m_data_reg  <= m_data_next;
    end

    // queue memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= wr_entry;
        end
        if (mem_re)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `SSB_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(QUEUE_DEPTH))
    `SSB_ASSERT_NOW(a_empty_ptrs, fill_reg == '0, head_reg == tail_reg)
    `SSB_ASSERT_NOW(a_exhausted_zero, mode_reg == ssb_pkg::MODE_EXHAUSTED, budget_reg == '0)
    `SSB_ASSERT_NOW(a_pop_nonempty, pop, (fill_reg != '0) && !mem_we)
    `SSB_ASSERT_NOW(a_grant_budget, m_axis_tvalid && m_axis_tdata[0],
                    (m_axis_tdata[34:3] != '0) && (m_axis_tdata[2:1] == ssb_pkg::MODE_ACTIVE))

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = ssb_pkg::QUEUE_DEPTH_DEF;

    // register addresses, index taken from paddr bit 2
    localparam logic [ssb_pkg::APB_AW-1:0] ADDR_LIMIT  = {ssb_pkg::REG_BUDGET_LIMIT, 2'b00};
    localparam logic [ssb_pkg::APB_AW-1:0] ADDR_PERIOD = {ssb_pkg::REG_PERIOD, 2'b00};

    localparam logic [ssb_pkg::TIME_W-1:0]   TIME_MAX   = '1;
    localparam logic [ssb_pkg::BUDGET_W-1:0] BUDGET_MAX = '1;

    // one command word as it travels on the input stream
    typedef struct {
        ssb_pkg::cmd_t              op;
        logic [ssb_pkg::TIME_W-1:0] stamp;
    } command_t;

    // result word, laid out as on m_axis_tdata (first member is the top bit)
    typedef struct packed {
        logic                          dropped;
        logic [ssb_pkg::PENDING_W-1:0] pending;
        logic [ssb_pkg::BUDGET_W-1:0]  budget;
        ssb_pkg::mode_t                mode;
        logic                          granted;
    } report_t;

    localparam int REPORT_W = $bits(report_t);

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [ssb_pkg::TIME_W-1:0]   s_axis_tdata  = '0;
    logic [1:0]                   s_axis_tuser  = ssb_pkg::CMD_ACTIVATE;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b1;
    logic [ssb_pkg::OUT_W-1:0]    m_axis_tdata;
    logic                         psel          = 1'b0;
    logic                         penable       = 1'b0;
    logic                         pwrite        = 1'b0;
    logic [ssb_pkg::APB_AW-1:0]   paddr         = '0;
    logic [ssb_pkg::APB_DW-1:0]   pwdata        = '0;
    logic [ssb_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    sporadic_server_budget_top #(
        .QUEUE_DEPTH (DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [63:0] now
        .s_axis_tuser  (s_axis_tuser),   // [1:0] cmd
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [0] consume_granted, [2:1] mode, [34:3] budget_left,
        // [39:35] pending_count, [40] push_dropped, [47:41] zero
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // budget engine shadow: configuration, server state, replenish ring
    // ------------------------------------------------------------------
    logic [ssb_pkg::BUDGET_W-1:0] lim_reg;
    logic [ssb_pkg::BUDGET_W-1:0] period_reg;
    ssb_pkg::mode_t               srv_mode;
    logic [ssb_pkg::BUDGET_W-1:0] budget_now;
    logic [ssb_pkg::BUDGET_W-1:0] ticks_used;
    logic [ssb_pkg::TIME_W-1:0]   job_start;
    logic [ssb_pkg::TIME_W-1:0]   due_mem [DEPTH];
    logic [ssb_pkg::BUDGET_W-1:0] amount_mem [DEPTH];
    int unsigned                  rd_ptr;
    int unsigned                  wr_ptr;
    int unsigned                  fill;

    // command words still to send, result words still to arrive
    command_t cmd_backlog [$];
    report_t  report_fifo [$];

    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked  = 0;
    int unsigned n_errors   = 0;
    int unsigned n_granted  = 0;
    int unsigned n_dropped  = 0;
    int unsigned n_drains   = 0;
    int unsigned n_writes   = 0;

    // random idle bursts on both streams, switched off for some phases
    bit          stall_on = 1'b1;
    int unsigned src_gap  = 0;
    int unsigned sink_gap = 0;

    // any register write reloads the budget and empties the ring
    function automatic void server_init();
        budget_now = lim_reg;
        ticks_used = '0;
        job_start  = '0;
        srv_mode   = ssb_pkg::MODE_IDLE;
        rd_ptr     = 0;
        wr_ptr     = 0;
        fill       = 0;
    endfunction

    // returns 1 when the ring is full and the entry is lost
    function automatic logic enqueue_replenish();
        if (fill >= DEPTH)
            return 1'b1;
        due_mem[wr_ptr]    = job_start + {32'd0, period_reg};
        amount_mem[wr_ptr] = ticks_used;
        wr_ptr             = (wr_ptr + 1) % DEPTH;
        fill++;
        return 1'b0;
    endfunction

    function automatic report_t advance_server(command_t c);
        report_t     r;
        logic [32:0] sum;
        r = '0;
        case (c.op)
            ssb_pkg::CMD_ACTIVATE:
            begin
                if (srv_mode == ssb_pkg::MODE_IDLE)
                begin
                    srv_mode   = ssb_pkg::MODE_ACTIVE;
                    job_start  = c.stamp;
                    ticks_used = '0;
                end
            end
            ssb_pkg::CMD_COMPLETE:
            begin
                // exhausted or idle servers ignore complete
                if (srv_mode == ssb_pkg::MODE_ACTIVE)
                begin
                    if (ticks_used != 0)
                        r.dropped = enqueue_replenish();
                    srv_mode   = ssb_pkg::MODE_IDLE;
                    ticks_used = '0;
                end
            end
            ssb_pkg::CMD_CONSUME:
            begin
                if (srv_mode != ssb_pkg::MODE_IDLE)
                begin
                    if (budget_now == 0)
                        srv_mode = ssb_pkg::MODE_EXHAUSTED;
                    else
                    begin
                        budget_now--;
                        if (ticks_used != BUDGET_MAX)
                            ticks_used++;
                        // last tick spent: replenish entry, not granted
                        if (budget_now == 0)
                        begin
                            r.dropped = enqueue_replenish();
                            srv_mode  = ssb_pkg::MODE_EXHAUSTED;
                        end
                        else
                            r.granted = 1'b1;
                    end
                end
            end
            default:
            begin
                // pop every entry due at or before now, capped refill
                while (fill > 0 && due_mem[rd_ptr] <= c.stamp)
                begin
                    sum    = {1'b0, budget_now} + {1'b0, amount_mem[rd_ptr]};
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    fill--;
                    if (sum > {1'b0, lim_reg})
                        sum = {1'b0, lim_reg};
                    budget_now = sum[ssb_pkg::BUDGET_W-1:0];
                    if (sum != 0 && srv_mode == ssb_pkg::MODE_EXHAUSTED)
                        srv_mode = ssb_pkg::MODE_ACTIVE;
                end
            end
        endcase
        r.mode    = srv_mode;
        r.budget  = budget_now;
        r.pending = ssb_pkg::PENDING_W'(fill);
        return r;
    endfunction

    function automatic void compare_field(input string label, input logic [31:0] want_v,
                                          input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch on word %0d, expected %0h, got %0h",
                     $time, label, n_checked, want_v, got_v);
            n_errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // command driver: feeds the backlog, predicts each accepted word
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        command_t seen;
        command_t nxt;
        report_t  want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                seen.op    = ssb_pkg::cmd_t'(s_axis_tuser);
                seen.stamp = s_axis_tdata;
                want       = advance_server(seen);
                report_fifo.push_back(want);
                n_accepted++;
                n_granted += want.granted;
                n_dropped += want.dropped;
                if (seen.op == ssb_pkg::CMD_DRAIN)
                    n_drains++;
            end
            // a word on the bus and not taken stays as it is
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (src_gap != 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (stall_on && cmd_backlog.size() != 0 && $urandom_range(0, 9) == 0)
                begin
                    // random idle burst
                    src_gap = $urandom_range(0, 7);
                    s_axis_tvalid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    nxt = cmd_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.stamp;
                    s_axis_tuser  <= nxt.op;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: checks every word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = report_t'(m_axis_tdata[REPORT_W-1:0]);
                if (report_fifo.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got %0h",
                             $time, m_axis_tdata);
                    n_errors++;
                end
                else
                begin
                    want = report_fifo.pop_front();
                    compare_field("consume_granted", want.granted, got.granted);
                    compare_field("mode", want.mode, got.mode);
                    compare_field("budget_left", want.budget, got.budget);
                    compare_field("pending_count", want.pending, got.pending);
                    compare_field("push_dropped", want.dropped, got.dropped);
                    compare_field("padding", '0, m_axis_tdata[ssb_pkg::OUT_W-1:REPORT_W]);
                    n_checked++;
                end
            end
            // back-pressure in random bursts
            if (sink_gap != 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_on && $urandom_range(0, 9) == 0)
            begin
                sink_gap = $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [ssb_pkg::TIME_W-1:0] rand_stamp();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_cmd(input ssb_pkg::cmd_t op, input logic [ssb_pkg::TIME_W-1:0] stamp);
        command_t c;
        c.op    = op;
        c.stamp = stamp;
        cmd_backlog.push_back(c);
        n_queued++;
    endtask

    // all words sent and all results seen
    task automatic wait_idle();
        while (n_accepted != n_queued || n_checked != n_accepted)
            @(posedge clk);
    endtask

    // setup then access cycle; write lands when pready is seen high
    task automatic reg_write(input logic [ssb_pkg::APB_AW-1:0] addr,
                             input logic [ssb_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_LIMIT)
            lim_reg = value;
        else
            period_reg = value;
        server_init();
        n_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_check(input logic [ssb_pkg::APB_AW-1:0] addr,
                             input logic [ssb_pkg::APB_DW-1:0] want_v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want_v)
        begin
            $display("%0t: register readback at %0h, expected %0h, got %0h",
                     $time, addr, want_v, prdata);
            n_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // mostly well-formed jobs (activate, ticks, complete) with drains
    // aimed around the due times, plus some random noise words
    task automatic gen_traffic(input int unsigned n_items, input int unsigned drain_pct);
        logic [ssb_pkg::TIME_W-1:0] t_now;
        logic [ssb_pkg::TIME_W-1:0] last_start;
        logic [ssb_pkg::TIME_W-1:0] due_guess;
        int unsigned                first;
        int unsigned                burst;
        first = n_queued;
        case ($urandom_range(0, 3))
            0:       t_now = ssb_pkg::TIME_W'($urandom_range(0, 100));
            1:       t_now = TIME_MAX - $urandom_range(0, 300);
            default: t_now = rand_stamp();
        endcase
        last_start = t_now;
        while (n_queued - first < n_items)
        begin
            if ($urandom_range(0, 99) < 15)
                queue_cmd(ssb_pkg::cmd_t'($urandom_range(0, 3)),
                          $urandom_range(0, 1) ? rand_stamp() : t_now + $urandom_range(0, 40));
            else
            begin
                queue_cmd(ssb_pkg::CMD_ACTIVATE, t_now);
                last_start = t_now;
                burst = (lim_reg < 24) ? $urandom_range(0, lim_reg + 2) : $urandom_range(0, 6);
                repeat (burst)
                    queue_cmd(ssb_pkg::CMD_CONSUME, rand_stamp());
                if ($urandom_range(0, 9) != 0)
                    queue_cmd(ssb_pkg::CMD_COMPLETE, rand_stamp());
                t_now += $urandom_range(1, 60);
                if ($urandom_range(0, 99) < drain_pct)
                begin
                    due_guess = last_start + {32'd0, period_reg};
                    case ($urandom_range(0, 4))
                        0:       queue_cmd(ssb_pkg::CMD_DRAIN, due_guess - 1);
                        1:       queue_cmd(ssb_pkg::CMD_DRAIN, due_guess);
                        2:       queue_cmd(ssb_pkg::CMD_DRAIN, due_guess + $urandom_range(0, 200));
                        3:       queue_cmd(ssb_pkg::CMD_DRAIN, t_now);
                        default: queue_cmd(ssb_pkg::CMD_DRAIN, rand_stamp());
                    endcase
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [ssb_pkg::BUDGET_W-1:0] lim_pick;
        logic [ssb_pkg::BUDGET_W-1:0] per_pick;
        lim_reg    = '0;
        period_reg = '0;
        server_init();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: zero limit, zero period
        queue_cmd(ssb_pkg::CMD_CONSUME, '0);           // consume while idle
        queue_cmd(ssb_pkg::CMD_ACTIVATE, '0);
        queue_cmd(ssb_pkg::CMD_ACTIVATE, TIME_MAX);    // ignored, already active
        queue_cmd(ssb_pkg::CMD_CONSUME, '0);           // zero budget, goes exhausted
        queue_cmd(ssb_pkg::CMD_COMPLETE, TIME_MAX);    // ignored while exhausted
        queue_cmd(ssb_pkg::CMD_DRAIN, TIME_MAX);       // empty ring
        wait_idle();

        // small budget, full-scale period so due times wrap
        reg_write(ADDR_LIMIT, 32'd3);
        reg_write(ADDR_PERIOD, BUDGET_MAX);
        queue_cmd(ssb_pkg::CMD_ACTIVATE, TIME_MAX);    // due wraps to 0xfffffffe
        queue_cmd(ssb_pkg::CMD_CONSUME, '0);
        queue_cmd(ssb_pkg::CMD_COMPLETE, '0);          // pushes one tick
        queue_cmd(ssb_pkg::CMD_DRAIN, '0);             // not due yet
        queue_cmd(ssb_pkg::CMD_ACTIVATE, 64'd10);
        queue_cmd(ssb_pkg::CMD_CONSUME, '0);
        queue_cmd(ssb_pkg::CMD_CONSUME, '0);           // empties budget, pushes
        queue_cmd(ssb_pkg::CMD_CONSUME, '0);           // zero budget
        queue_cmd(ssb_pkg::CMD_DRAIN, 64'hFFFF_FFFD);  // one short of due, stays exhausted
        queue_cmd(ssb_pkg::CMD_DRAIN, 64'hFFFF_FFFE);  // exactly due, back to active
        queue_cmd(ssb_pkg::CMD_CONSUME, '0);           // empties again
        queue_cmd(ssb_pkg::CMD_DRAIN, TIME_MAX);       // both due, refill capped at limit
        queue_cmd(ssb_pkg::CMD_COMPLETE, '0);
        queue_cmd(ssb_pkg::CMD_ACTIVATE, 64'd77);
        queue_cmd(ssb_pkg::CMD_COMPLETE, '0);          // nothing consumed, no push
        wait_idle();

        // random phases across limit and period settings
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    lim_pick = 32'd1;
                    per_pick = '0;
                end
                1:
                begin
                    lim_pick = BUDGET_MAX;
                    per_pick = BUDGET_MAX;
                end
                2:
                begin
                    lim_pick = '0;
                    per_pick = 32'd7;
                end
                3:
                begin
                    lim_pick = $urandom_range(2, 12);
                    per_pick = $urandom_range(0, 30);
                end
                4:
                begin
                    lim_pick = $urandom;
                    per_pick = $urandom;
                end
                5:
                begin
                    lim_pick = $urandom_range(3, 8);
                    per_pick = BUDGET_MAX - $urandom_range(0, 3);
                end
                6:
                begin
                    lim_pick = $urandom_range(1, 20);
                    per_pick = $urandom_range(0, 100);
                end
                default:
                begin
                    lim_pick = $urandom_range(2, 10);
                    per_pick = $urandom_range(0, 20);
                end
            endcase
            wait_idle();
            // no idling in phase 3 and in the closing phase
            stall_on = (phase != 3 && phase != 7);
            if ($urandom_range(0, 1))
            begin
                reg_write(ADDR_LIMIT, lim_pick);
                reg_write(ADDR_PERIOD, per_pick);
            end
            else
            begin
                reg_write(ADDR_PERIOD, per_pick);
                reg_write(ADDR_LIMIT, lim_pick);
            end
            reg_check(ADDR_LIMIT, lim_pick);
            reg_check(ADDR_PERIOD, per_pick);
            // large budgets rarely drain so the ring fills and drops entries
            gen_traffic(100, (phase == 1 || phase == 4) ? 10 : 35);
        end

        wait_idle();
        // catch stray words after the last expected one
        repeat (40) @(posedge clk);

        $display("covered %0d command words (%0d drains) across %0d register writes",
                 n_accepted, n_drains, n_writes);
        $display("%0d ticks granted, %0d replenish entries lost to a full ring",
                 n_granted, n_dropped);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, well above the slowest legal run
    initial
    begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ssb_pkg.sv
rtl/core/sporadic_server_budget_top.sv
test/tb.sv
